### src/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

  localparam int HeapBytesDef   = 65536;
  localparam int MaxBlocksDef   = 64;
  localparam int HeaderBytesDef = 32;
  // alignment is a power of two
  localparam int AlignBytesDef  = 8;

  localparam int OpW     = 2;
  localparam int ReqW    = 17;
  localparam int AddrW   = 16;
  localparam int StatusW = 3;
  localparam int UsedW   = 7;
  localparam int BytesW  = 17;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_COALESCE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_ARENA     = 3'd2,
    ST_TABLE     = 3'd3,
    ST_UNMATCHED = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // latch request, clear totals
    logic walk_start;  // read the first block, restart the walk
    logic alloc_step;  // examine current block for a fit
    logic split_wr;    // write the split-off remainder
    logic append;      // add a block at the arena top
    logic link_wr;     // hook the appended block to the old last block
    logic free_step;
    logic coal_load;   // take the first block as merge base
    logic coal_step;
    logic stat_step;
  } ffba_cmd_t;

  typedef struct packed {
    logic skip;        // request ignored, only the status walk runs
    logic at_end;      // walk ran off the list or hit the step limit
    logic hit;         // alloc fit or free match on this step
    logic need_split;
  } ffba_sts_t;

endpackage
`default_nettype wire

### src/ffba_ctrl.sv
`default_nettype none
module ffba_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  input  wire logic [ffba_pkg::OpW-1:0] op,
  output ffba_pkg::ffba_cmd_t           cmd,
  input  wire ffba_pkg::ffba_sts_t      sts
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ALLOC, S_SPLIT, S_APPEND, S_LINK, S_FREE, S_CLOAD, S_COAL,
    S_SSTART, S_STAT, S_OUT
  } state_t;

  state_t state_r;
  logic [OpW-1:0] op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          if (sts.skip) begin
            state_r <= S_STAT;
          end else begin
            case (op_r)
              OP_ALLOC:    state_r <= S_ALLOC;
              OP_FREE:     state_r <= S_FREE;
              OP_COALESCE: state_r <= S_CLOAD;
              default:     state_r <= S_STAT;
            endcase
          end
        end
        S_ALLOC: begin
          if (sts.at_end) state_r <= S_APPEND;
          else if (sts.hit) state_r <= sts.need_split ? S_SPLIT : S_SSTART;
        end
        S_SPLIT:  state_r <= S_SSTART;
        S_APPEND: state_r <= S_LINK;
        S_LINK:   state_r <= S_SSTART;
        S_FREE: begin
          if (sts.at_end || sts.hit) state_r <= S_SSTART;
        end
        S_CLOAD: begin
          if (sts.at_end) state_r <= S_SSTART;
          else state_r <= S_COAL;
        end
        S_COAL: begin
          if (sts.at_end) state_r <= S_SSTART;
        end
        S_SSTART: state_r <= S_STAT;
        S_STAT: begin
          if (sts.at_end) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load       = (state_r == S_IDLE) && in_valid;
    cmd.walk_start = (state_r == S_DISP) || (state_r == S_SSTART);
    cmd.alloc_step = (state_r == S_ALLOC);
    cmd.split_wr   = (state_r == S_SPLIT);
    cmd.append     = (state_r == S_APPEND);
    cmd.link_wr    = (state_r == S_LINK);
    cmd.free_step  = (state_r == S_FREE);
    cmd.coal_load  = (state_r == S_CLOAD);
    cmd.coal_step  = (state_r == S_COAL);
    cmd.stat_step  = (state_r == S_STAT);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("ready and valid together");
  a_out_after_stat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_STAT))
    else $error("result without status walk");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
`endif
endmodule
`default_nettype wire

### src/ffba_dp.sv
`default_nettype none
module ffba_dp #(
  parameter int HEAP_BYTES   = ffba_pkg::HeapBytesDef,
  parameter int MAX_BLOCKS   = ffba_pkg::MaxBlocksDef,
  parameter int HEADER_BYTES = ffba_pkg::HeaderBytesDef,
  parameter int ALIGN_BYTES  = ffba_pkg::AlignBytesDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [ffba_pkg::OpW-1:0]   op,
  input  wire logic [ffba_pkg::ReqW-1:0]  request_bytes,
  input  wire logic [ffba_pkg::AddrW-1:0] payload_address,
  input  wire ffba_pkg::ffba_cmd_t        cmd,
  output ffba_pkg::ffba_sts_t             sts,
  output logic [ffba_pkg::StatusW-1:0]    status,
  output logic [ffba_pkg::AddrW-1:0]      granted_address,
  output logic [ffba_pkg::UsedW-1:0]      used_blocks,
  output logic [ffba_pkg::BytesW-1:0]     free_bytes,
  output logic [ffba_pkg::BytesW-1:0]     largest_free
);
  import ffba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = $clog2(MAX_BLOCKS);
  localparam int HW = $clog2(HEAP_BYTES + 1);
  localparam int AW = ((HW > ReqW) ? HW : ReqW) + 1;
  localparam int SW = $clog2(2 * MAX_BLOCKS + 1);
  localparam int AlignSh = $clog2(ALIGN_BYTES);
  localparam logic [IW-1:0] NoneIdx = IW'(MAX_BLOCKS);

  // block table, one field per array
  logic [AW-1:0] bytes_m [MAX_BLOCKS];
  logic          used_m  [MAX_BLOCKS];
  logic [IW-1:0] link_m  [MAX_BLOCKS];

  logic [IW-1:0] first_r, last_r, cur_r, spare_idx, nb_r, split_link_r, fix_idx_r;
  logic [AW-1:0] top_r, addr_r, need_r, split_bytes_r;
  logic [MAX_BLOCKS-1:0] spare_r;
  logic [SW-1:0] steps_r;
  logic [AddrW-1:0] pay_r;
  logic [StatusW-1:0] status_r;
  logic [AddrW-1:0] grant_r;
  logic [UsedW-1:0] used_r;
  logic [AW-1:0] freeb_r, large_r;
  logic skip_r, fix_r;

  // registered read of the entry at cur
  logic [AW-1:0] rb_r;
  logic          ru_r;
  logic [IW-1:0] rl_r;
  logic [IW-1:0] rd_addr;

  // merge base for coalesce
  logic [AW-1:0] c_bytes_r;
  logic          c_used_r;
  logic [IW-1:0] c_link_r;

  logic [AW:0] need_raw;
  logic skip_in;
  assign need_raw = (AW+1)'(request_bytes) + (AW+1)'(HEADER_BYTES + ALIGN_BYTES - 1);
  assign skip_in  = (op == OP_ALLOC && request_bytes == '0) ||
                    (op == OP_FREE && payload_address == '0) || (op == OP_NONE);

  // lowest spare entry
  always_comb begin
    spare_idx = NoneIdx;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (spare_r[i]) spare_idx = IW'(i);
    end
  end

  logic at_end, fit, rest_ok, match, merge, arena_bad, has_spare;
  logic alloc_hit, do_split, free_hit, coal_merge, append_ok, advance;
  assign has_spare  = (spare_idx != NoneIdx);
  assign fit        = !ru_r && (rb_r >= need_r);
  assign rest_ok    = (rb_r - need_r) >= AW'(HEADER_BYTES);
  assign match      = (addr_r + AW'(HEADER_BYTES)) == AW'(pay_r);
  assign merge      = !c_used_r && !ru_r;
  assign arena_bad  = (need_r > AW'(HEAP_BYTES)) || (top_r > AW'(HEAP_BYTES) - need_r);
  assign at_end     = cmd.coal_step ?
                      ((c_link_r >= NoneIdx) || (steps_r >= SW'(2 * MAX_BLOCKS))) :
                      ((cur_r >= NoneIdx) || (steps_r >= SW'(MAX_BLOCKS)));
  assign alloc_hit  = cmd.alloc_step && !at_end && fit;
  assign do_split   = alloc_hit && rest_ok && has_spare;
  assign free_hit   = cmd.free_step && !at_end && match;
  assign coal_merge = cmd.coal_step && !at_end && merge;
  assign append_ok  = cmd.append && !arena_bad && has_spare;
  assign advance    = !at_end &&
                      ((cmd.alloc_step && !fit) || (cmd.free_step && !match) || cmd.stat_step);

  always_comb begin
    sts = '0;
    sts.skip       = skip_r;
    sts.at_end     = at_end;
    sts.hit        = cmd.free_step ? match : fit;
    sts.need_split = rest_ok && has_spare;
  end

  // next read follows the link of the entry just read
  assign rd_addr = cmd.walk_start ? first_r : rl_r;

  // one write per array per cycle
  logic          b_we, u_we, l_we, u_wd;
  logic [XW-1:0] b_wa, u_wa, l_wa;
  logic [AW-1:0] b_wd;
  logic [IW-1:0] l_wd;
  always_comb begin
    b_we = 1'b0; b_wa = cur_r[XW-1:0]; b_wd = need_r;
    u_we = 1'b0; u_wa = cur_r[XW-1:0]; u_wd = 1'b0;
    l_we = 1'b0; l_wa = cur_r[XW-1:0]; l_wd = spare_idx;
    if (alloc_hit) begin
      u_we = 1'b1; u_wd = 1'b1;
      if (do_split) begin
        b_we = 1'b1;
        l_we = 1'b1;
      end
    end else if (free_hit) begin
      u_we = 1'b1;
    end else if (coal_merge) begin
      b_we = 1'b1; b_wd = c_bytes_r + rb_r;
      l_we = 1'b1; l_wd = rl_r;
    end else if (cmd.split_wr) begin
      b_we = 1'b1; b_wa = nb_r[XW-1:0]; b_wd = split_bytes_r;
      u_we = 1'b1; u_wa = nb_r[XW-1:0];
      l_we = 1'b1; l_wa = nb_r[XW-1:0]; l_wd = split_link_r;
    end else if (append_ok) begin
      b_we = 1'b1; b_wa = spare_idx[XW-1:0];
      u_we = 1'b1; u_wa = spare_idx[XW-1:0]; u_wd = 1'b1;
      l_we = 1'b1; l_wa = spare_idx[XW-1:0]; l_wd = NoneIdx;
    end else if (cmd.link_wr && fix_r) begin
      l_we = 1'b1; l_wa = fix_idx_r[XW-1:0]; l_wd = nb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) bytes_m[b_wa] <= b_wd;
    if (u_we) used_m[u_wa] <= u_wd;
    if (l_we) link_m[l_wa] <= l_wd;
    rb_r <= bytes_m[rd_addr[XW-1:0]];
    ru_r <= used_m[rd_addr[XW-1:0]];
    rl_r <= link_m[rd_addr[XW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= NoneIdx;
      last_r  <= NoneIdx;
      top_r   <= '0;
      spare_r <= '1;
    end else begin
      if (cmd.load) begin
        pay_r    <= payload_address;
        need_r   <= AW'((need_raw >> AlignSh) << AlignSh);
        skip_r   <= skip_in;
        status_r <= skip_in ? ST_IGNORED : ST_OK;
        grant_r  <= '0;
        used_r   <= '0;
        freeb_r  <= '0;
        large_r  <= '0;
        fix_r    <= 1'b0;
      end
      if (cmd.walk_start) begin
        cur_r   <= first_r;
        steps_r <= '0;
        addr_r  <= '0;
      end else if (advance) begin
        cur_r   <= rl_r;
        steps_r <= steps_r + 1'b1;
        addr_r  <= addr_r + rb_r;
      end
      if (alloc_hit) begin
        grant_r <= AddrW'(addr_r + AW'(HEADER_BYTES));
        if (do_split) begin
          spare_r[spare_idx[XW-1:0]] <= 1'b0;
          nb_r          <= spare_idx;
          split_bytes_r <= rb_r - need_r;
          split_link_r  <= rl_r;
          if (last_r == cur_r) last_r <= spare_idx;
        end
      end
      if (cmd.free_step && at_end) status_r <= ST_UNMATCHED;
      if (cmd.coal_load && !at_end) begin
        c_bytes_r <= rb_r;
        c_used_r  <= ru_r;
        c_link_r  <= rl_r;
      end
      if (cmd.coal_step && !at_end) begin
        steps_r <= steps_r + 1'b1;
        if (merge) begin
          c_bytes_r <= c_bytes_r + rb_r;
          c_link_r  <= rl_r;
          spare_r[c_link_r[XW-1:0]] <= 1'b1;
          if (last_r == c_link_r) last_r <= cur_r;
        end else begin
          cur_r     <= c_link_r;
          c_bytes_r <= rb_r;
          c_used_r  <= ru_r;
          c_link_r  <= rl_r;
        end
      end
      if (cmd.append) begin
        if (arena_bad) status_r <= ST_ARENA;
        else if (!has_spare) status_r <= ST_TABLE;
        else begin
          spare_r[spare_idx[XW-1:0]] <= 1'b0;
          nb_r <= spare_idx;
          if (first_r == NoneIdx) first_r <= spare_idx;
          else if (last_r != NoneIdx) begin
            fix_r     <= 1'b1;
            fix_idx_r <= last_r;
          end
          last_r  <= spare_idx;
          grant_r <= AddrW'(top_r + AW'(HEADER_BYTES));
          top_r   <= top_r + need_r;
        end
      end
      if (cmd.stat_step && !at_end) begin
        if (ru_r) used_r <= used_r + 1'b1;
        else begin
          freeb_r <= freeb_r + rb_r;
          if (rb_r > large_r) large_r <= rb_r;
        end
      end
    end
  end

  assign status          = status_r;
  assign granted_address = grant_r;
  assign used_blocks     = used_r;
  assign free_bytes      = BytesW'(freeb_r);
  assign largest_free    = BytesW'(large_r);
endmodule
`default_nettype wire

### src/first_fit_block_allocator_unit.sv
`default_nettype none
// first-fit heap allocator over a bounded arena; each request (allocate, free,
// coalesce) walks the address-ordered block list one entry per cycle out of a
// block table with registered reads, then a second walk gathers used count,
// free bytes and largest free block; the result holds until taken and the next
// request is taken the cycle after; one request at a time; the alignment must
// be a power of two
module first_fit_block_allocator_unit #(
  parameter int HEAP_BYTES   = ffba_pkg::HeapBytesDef,
  parameter int MAX_BLOCKS   = ffba_pkg::MaxBlocksDef,
  parameter int HEADER_BYTES = ffba_pkg::HeaderBytesDef,
  parameter int ALIGN_BYTES  = ffba_pkg::AlignBytesDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ffba_pkg::OpW-1:0]      in_op,
  input  wire logic [ffba_pkg::ReqW-1:0]     in_request_bytes,
  input  wire logic [ffba_pkg::AddrW-1:0]    in_payload_address,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ffba_pkg::StatusW-1:0]       out_status,
  output logic [ffba_pkg::AddrW-1:0]         out_granted_address,
  output logic [ffba_pkg::UsedW-1:0]         out_used_blocks,
  output logic [ffba_pkg::BytesW-1:0]        out_free_bytes,
  output logic [ffba_pkg::BytesW-1:0]        out_largest_free
);
  import ffba_pkg::*;

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  // sequencer
  ffba_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .op(in_op), .cmd, .sts
  );

  // block table and walk datapath
  ffba_dp #(
    .HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
  ) u_dp (
    .clk, .rst_n, .op(in_op), .request_bytes(in_request_bytes),
    .payload_address(in_payload_address), .cmd, .sts,
    .status(out_status), .granted_address(out_granted_address),
    .used_blocks(out_used_blocks), .free_bytes(out_free_bytes),
    .largest_free(out_largest_free)
  );
endmodule
`default_nettype wire
